// ----- rtl/hsrp_pkg.sv -----
// ---------------------------------------------------------------------------
// hsrp_pkg
// Shared types, constants and helpers of the hex status record parser.
// ---------------------------------------------------------------------------
`default_nettype none

package hsrp_pkg;

  localparam int MAX_REPLY_CHARS = 128;
  localparam int CHAR_CNT_W      = $clog2(MAX_REPLY_CHARS + 1);

  localparam logic [7:0] ABORT_BIT   = 8'h80;
  localparam logic [7:0] FAIL_BIT    = 8'h40;
  localparam logic [7:0] COUNT_MASK  = 8'h3f;
  localparam logic [6:0] COUNTER_MAX = 7'd127;
  localparam logic [6:0] INDEX_LIMIT = 7'd64;
  localparam logic [6:0] MAX_CMDS_RST = 7'd64;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_FINAL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABORTED   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // one input beat
  typedef struct packed {
    logic       cmd;
    logic [7:0] char_in;
  } item_t;

  // input stage toward the decoder
  typedef struct packed {
    logic  vld;
    item_t item;
  } stage_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] cmd_index;
    logic [7:0] data_byte;
    logic [5:0] byte_count;
    logic       failed;
    status_t    status;
    logic [6:0] ok_count;
  } result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsrp_if.sv -----
// ---------------------------------------------------------------------------
// hsrp_in_if / hsrp_out_if
// Valid/ready channels of the parser: character beats in, result beats out.
// ---------------------------------------------------------------------------
`default_nettype none

interface hsrp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_in;

  modport source(output valid, cmd, char_in, input ready);
  modport sink(input valid, cmd, char_in, output ready);
endinterface

interface hsrp_out_if;
  logic                valid;
  logic                ready;
  hsrp_pkg::kind_t     kind;
  logic [5:0]          cmd_index;
  logic [7:0]          data_byte;
  logic [5:0]          byte_count;
  logic                failed;
  hsrp_pkg::status_t   status;
  logic [6:0]          ok_count;

  modport source(output valid, kind, cmd_index, data_byte, byte_count, failed, status,
                 ok_count, input ready);
  modport sink(input valid, kind, cmd_index, data_byte, byte_count, failed, status,
               ok_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsrp_in_reg.sv -----
// ---------------------------------------------------------------------------
// hsrp_in_reg
// Input register: holds one accepted beat until the decoder takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hsrp_in_reg (
  input  wire               clk,
  input  wire               rst_n,
  hsrp_in_if.sink           in_ch,
  input  wire               step,
  output hsrp_pkg::stage_t  stage
);

  logic            vld_r, vld_nxt;
  hsrp_pkg::item_t item_r;
  logic            accept;

  assign in_ch.ready = !vld_r || step;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) vld_nxt = 1'b1;
    else if (step) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd     <= in_ch.cmd;
      item_r.char_in <= in_ch.char_in;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

`default_nettype wire

// ----- rtl/hsrp_parse.sv -----
// ---------------------------------------------------------------------------
// hsrp_parse
// Frame decoder: hex pairing, status/data phases, counters, result select.
// ---------------------------------------------------------------------------
`default_nettype none

module hsrp_parse (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [6:0]                 cfg_wdata,
  input  hsrp_pkg::stage_t          stage,
  input  wire                       step,
  output logic                      res_vld,
  output hsrp_pkg::result_t         res
);

  logic [6:0]                      max_cmds_r;
  logic                            have_hi_r, have_hi_nxt;
  logic [3:0]                      hi_nib_r, hi_nib_nxt;
  logic                            in_data_r, in_data_nxt;
  logic [5:0]                      rem_r, rem_nxt;
  logic [6:0]                      cmd_cnt_r, cmd_cnt_nxt;
  logic [6:0]                      ok_cnt_r, ok_cnt_nxt;
  logic                            stopped_r, stopped_nxt;
  hsrp_pkg::status_t               err_r, err_nxt;
  logic [hsrp_pkg::CHAR_CNT_W-1:0] chars_r, chars_nxt;

  logic [6:0]        lim;
  logic              stored;
  logic [4:0]        nib;
  logic [7:0]        val;
  logic [6:0]        cmd_cnt_inc;
  hsrp_pkg::status_t fin_st;

  assign lim         = (max_cmds_r > hsrp_pkg::INDEX_LIMIT) ? hsrp_pkg::INDEX_LIMIT
                                                            : max_cmds_r;
  assign stored      = cmd_cnt_r < lim;
  assign nib         = hsrp_pkg::hex_value(stage.item.char_in);
  assign val         = {hi_nib_r, nib[3:0]};
  assign cmd_cnt_inc = (cmd_cnt_r < hsrp_pkg::COUNTER_MAX) ? cmd_cnt_r + 7'd1 : cmd_cnt_r;

  always_comb begin
    have_hi_nxt = have_hi_r;
    hi_nib_nxt  = hi_nib_r;
    in_data_nxt = in_data_r;
    rem_nxt     = rem_r;
    cmd_cnt_nxt = cmd_cnt_r;
    ok_cnt_nxt  = ok_cnt_r;
    stopped_nxt = stopped_r;
    err_nxt     = err_r;
    chars_nxt   = chars_r;
    res_vld     = 1'b0;
    res         = '0;
    fin_st      = err_r;
    if (err_r == hsrp_pkg::ST_OK && in_data_r) fin_st = hsrp_pkg::ST_TRUNCATED;

    if (step) begin
      if (stage.item.cmd) begin
        res_vld      = 1'b1;
        res.kind     = hsrp_pkg::KIND_FINAL;
        res.status   = fin_st;
        res.ok_count = (fin_st == hsrp_pkg::ST_OK) ? ok_cnt_r : 7'd0;
        have_hi_nxt  = 1'b0;
        hi_nib_nxt   = '0;
        in_data_nxt  = 1'b0;
        rem_nxt      = '0;
        cmd_cnt_nxt  = '0;
        ok_cnt_nxt   = '0;
        stopped_nxt  = 1'b0;
        err_nxt      = hsrp_pkg::ST_OK;
        chars_nxt    = '0;
      end else if (!stopped_r && chars_r < hsrp_pkg::CHAR_CNT_W'(hsrp_pkg::MAX_REPLY_CHARS)) begin
        chars_nxt = chars_r + hsrp_pkg::CHAR_CNT_W'(1);
        if (nib[4]) begin
          stopped_nxt = 1'b1;
          have_hi_nxt = 1'b0;
          if (in_data_r) err_nxt = hsrp_pkg::ST_TRUNCATED;
        end else if (!have_hi_r) begin
          have_hi_nxt = 1'b1;
          hi_nib_nxt  = nib[3:0];
        end else begin
          have_hi_nxt = 1'b0;
          if (in_data_r) begin
            if (stored) begin
              res_vld       = 1'b1;
              res.kind      = hsrp_pkg::KIND_DATA;
              res.cmd_index = cmd_cnt_r[5:0];
              res.data_byte = val;
            end
            // data phase always has at least one byte left
            rem_nxt = rem_r - 6'd1;
            if (rem_r == 6'd1) begin
              in_data_nxt = 1'b0;
              cmd_cnt_nxt = cmd_cnt_inc;
            end
          end else if ((val & hsrp_pkg::ABORT_BIT) != 8'h00) begin
            stopped_nxt = 1'b1;
            err_nxt     = hsrp_pkg::ST_ABORTED;
          end else begin
            if ((val & hsrp_pkg::FAIL_BIT) == 8'h00 && ok_cnt_r < hsrp_pkg::COUNTER_MAX)
              ok_cnt_nxt = ok_cnt_r + 7'd1;
            if (stored) begin
              res_vld        = 1'b1;
              res.kind       = hsrp_pkg::KIND_RECORD;
              res.cmd_index  = cmd_cnt_r[5:0];
              res.byte_count = val[5:0];
              res.failed     = val[6];
            end
            if (val[5:0] != 6'd0) begin
              in_data_nxt = 1'b1;
              rem_nxt     = val[5:0];
            end else begin
              cmd_cnt_nxt = cmd_cnt_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cmds_r <= hsrp_pkg::MAX_CMDS_RST;
      have_hi_r  <= 1'b0;
      hi_nib_r   <= '0;
      in_data_r  <= 1'b0;
      rem_r      <= '0;
      cmd_cnt_r  <= '0;
      ok_cnt_r   <= '0;
      stopped_r  <= 1'b0;
      err_r      <= hsrp_pkg::ST_OK;
      chars_r    <= '0;
    end else begin
      if (cfg_we) max_cmds_r <= cfg_wdata;
      have_hi_r <= have_hi_nxt;
      hi_nib_r  <= hi_nib_nxt;
      in_data_r <= in_data_nxt;
      rem_r     <= rem_nxt;
      cmd_cnt_r <= cmd_cnt_nxt;
      ok_cnt_r  <= ok_cnt_nxt;
      stopped_r <= stopped_nxt;
      err_r     <= err_nxt;
      chars_r   <= chars_nxt;
    end
  end

  a_rem_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_data_r |-> rem_r != 6'd0)
    else $error("data phase with no bytes left");

  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_data_r |-> rem_r == 6'd0)
    else $error("bytes left outside data phase");

  a_stop_no_hi: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !have_hi_r)
    else $error("pending digit while stopped");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && stage.item.cmd |=> cmd_cnt_r == 7'd0 && !stopped_r && chars_r == '0)
    else $error("frame state not cleared by end beat");

  a_chars_max: assert property (@(posedge clk) disable iff (!rst_n)
    chars_r <= hsrp_pkg::CHAR_CNT_W'(hsrp_pkg::MAX_REPLY_CHARS))
    else $error("character count beyond frame limit");

endmodule

`default_nettype wire

// ----- rtl/hsrp_out_reg.sv -----
// ---------------------------------------------------------------------------
// hsrp_out_reg
// Result register: holds one result beat until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hsrp_out_reg (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                load,
  input  hsrp_pkg::result_t  res,
  output logic               free,
  hsrp_out_if.source         out_ch
);

  logic              vld_r, vld_nxt;
  hsrp_pkg::result_t res_r;

  assign free = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) vld_nxt = 1'b1;
    else if (out_ch.ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.cmd_index  = res_r.cmd_index;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.byte_count = res_r.byte_count;
  assign out_ch.failed     = res_r.failed;
  assign out_ch.status     = res_r.status;
  assign out_ch.ok_count   = res_r.ok_count;

endmodule

`default_nettype wire

// ----- rtl/hex_status_record_parser.sv -----
// ---------------------------------------------------------------------------
// hex_status_record_parser
// Decodes an ASCII hex reply frame into command records, data bytes and a
// final frame result.
// ---------------------------------------------------------------------------
// Takes one character beat per cycle while the output side does not stall,
// with no gaps between frames. A beat sits in the input register, is decoded
// once the result register is free by a single pass of hex lookup and counter
// update, and its result, if any, is loaded into the result register. The
// result register is the only buffer on the output side: while it holds an
// untaken beat, the decoder waits and in_ch.ready falls once the input
// register is also full; out ready reaches in ready combinationally.
// max_stored_commands is written through cfg_we/cfg_wdata and should only
// change between frames with no beat in flight.
`default_nettype none

module hex_status_record_parser (
  input  wire         clk,
  input  wire         rst_n,
  hsrp_in_if.sink     in_ch,
  hsrp_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire [6:0]   cfg_wdata
);

  hsrp_pkg::stage_t  stage;
  hsrp_pkg::result_t res;
  logic              res_vld;
  logic              out_free;
  logic              step;

  assign step = stage.vld && out_free;

  hsrp_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .step  (step),
    .stage (stage)
  );

  hsrp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .step      (step),
    .res_vld   (res_vld),
    .res       (res)
  );

  hsrp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_vld),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
